/* rtl/lfo_trem_pkg.sv */
// Package for the LFO tremolo gate: widths, register indexes and the sine table.
// Used by lfo_tremolo_gate_top; depends on nothing else.
package lfo_trem_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SAMPLE_BITS     = 24;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QUARTER         = 1 << QUARTER_BITS;
   localparam int MAG_BITS        = 15;
   localparam int GAIN_BITS       = 17;
   localparam int PROD_BITS       = SAMPLE_BITS + GAIN_BITS;
   localparam int SHIFT_BITS      = PROD_BITS - 15;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [31:0] MIN_ACTIVE_STEP_RESET = 32'd13422;
   localparam logic signed [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(32768);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP      = 2'd0,
      CSR_MIN_ACTIVE_STEP = 2'd1,
      CSR_WIDTH_THRESHOLD = 2'd2,
      CSR_SQUARE_MODE     = 2'd3
   } csr_index_type;

   typedef logic [MAG_BITS-1:0] sine_rom_type [QUARTER];

   // quarter-wave magnitude in Q0.15 for position k of 0..QUARTER
   function automatic logic [MAG_BITS-1:0] sine_mag(input int k);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      logic [63:0] s16;
      logic [63:0] mag;
      u   = 64'(k) << (18 - SINE_TABLE_BITS);
      u2  = (u * u) >> 16;
      t   = (64'd307 * u2) >> 16;
      t   = ((64'd5223 - t) * u2) >> 16;
      t   = ((64'd42334 - t) * u2) >> 16;
      s16 = ((64'd102944 - t) * u) >> 16;
      mag = (s16 + 64'd1) >> 1;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return mag[MAG_BITS-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i < QUARTER; i++) begin
         rom[i] = sine_mag(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [MAG_BITS-1:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

/* rtl/lfo_tremolo_gate_top.sv */
// LFO tremolo gate top: phase accumulator, quarter-wave sine lookup, threshold
// gating, gain multiply, rounding, saturation, bypass. Uses lfo_trem_pkg.
//
//   channel   dir   handshake          payload
//   req_      in    tvalid / tready    tdata[23:0] sample_in
//   rsp_      out   tvalid / tready    tdata[23:0] sample_out
//   csr_      in    we                 index[1:0], wdata[31:0]
//
// One request per cycle unless stalled; input register, then result register.
// The critical path is the sine table read, the 24x17 multiply and saturation.
// Reset is synchronous: phase to zero, registers to defaults, both stages empty.
// A stalled result holds in the result register while one more request fills
// the input register.
module lfo_tremolo_gate_top
   import lfo_trem_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [SAMPLE_BITS-1:0]    req_tdata,   // [23:0] sample_in
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [SAMPLE_BITS-1:0]    rsp_tdata,   // [23:0] sample_out
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [31:0]           phase_step_ff;
   logic [31:0]           min_active_step_ff;
   logic [MAG_BITS-1:0]   width_threshold_ff;
   logic                  square_mode_ff;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic                  s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                  rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_data_ff;
   logic [SAMPLE_BITS-1:0] rsp_data_in;

   logic req_accept;
   logic s1_move;

   logic [SINE_TABLE_BITS-1:0] sine_idx;
   logic [1:0]                 quad;
   logic [QUARTER_BITS:0]      kpos;
   logic [MAG_BITS-1:0]        mag;
   logic signed [GAIN_BITS-1:0] sine_val;
   logic signed [GAIN_BITS-1:0] gain;
   logic                       active;
   logic signed [PROD_BITS-1:0] product;
   logic signed [PROD_BITS-1:0] rounded;
   logic signed [SHIFT_BITS-1:0] scaled;

   localparam logic signed [SHIFT_BITS-1:0] SAT_MAX =
      SHIFT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [SHIFT_BITS-1:0] SAT_MIN =
      SHIFT_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff      <= '0;
         min_active_step_ff <= MIN_ACTIVE_STEP_RESET;
         width_threshold_ff <= '0;
         square_mode_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PHASE_STEP:      phase_step_ff      <= csr_wdata[31:0];
            CSR_MIN_ACTIVE_STEP: min_active_step_ff <= csr_wdata[31:0];
            CSR_WIDTH_THRESHOLD: width_threshold_ff <= csr_wdata[MAG_BITS-1:0];
            CSR_SQUARE_MODE:     square_mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;
   assign phase_in   = phase_ff + PHASE_BITS'(phase_step_ff);

   // phase advances with every request; the input stage sees the new phase
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff <= phase_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // sine from the quarter-wave table
   always_comb begin
      sine_idx = phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
      quad     = sine_idx[SINE_TABLE_BITS-1 -: 2];
      if (quad[0]) begin
         kpos = (QUARTER_BITS+1)'(QUARTER) - {1'b0, sine_idx[QUARTER_BITS-1:0]};
      end else begin
         kpos = {1'b0, sine_idx[QUARTER_BITS-1:0]};
      end
      if (kpos[QUARTER_BITS]) begin
         mag = SINE_PEAK;
      end else begin
         mag = SINE_ROM[kpos[QUARTER_BITS-1:0]];
      end
      if (quad[1]) begin
         sine_val = -$signed({2'b00, mag});
      end else begin
         sine_val = $signed({2'b00, mag});
      end
   end

   // gain, multiply, round, saturate; pass the sample through when inactive
   always_comb begin
      active = phase_step_ff > min_active_step_ff;
      if (sine_val < $signed({2'b00, width_threshold_ff})) begin
         gain = '0;
      end else if (square_mode_ff) begin
         gain = GAIN_UNITY;
      end else begin
         gain = sine_val;
      end
      product = PROD_BITS'(s1_sample_ff) * PROD_BITS'(gain);
      rounded = product + PROD_BITS'(16384);
      scaled  = rounded[PROD_BITS-1:15];
      if (!active) begin
         rsp_data_in = s1_sample_ff;
      end else if (scaled > SAT_MAX) begin
         rsp_data_in = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (scaled < SAT_MIN) begin
         rsp_data_in = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         rsp_data_in = scaled[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_bypass_passes: assert property (@(posedge clock) disable iff (reset)
      s1_move && !active |=> rsp_tdata == $past(s1_sample_ff))
      else $error("bypassed sample altered");

   a_zero_gain: assert property (@(posedge clock) disable iff (reset)
      s1_move && active && gain == '0 |=> rsp_tdata == '0)
      else $error("gated sample not zero");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |-> !req_tready)
      else $error("input stage overrun");

endmodule
